// ===== hdl/tsd_pkg.sv =====
`timescale 1ns / 1ps
// tsd_pkg: shared types and constants of the touch swipe direction detector
// depends on nothing; imported by every tsd module and the top level

package tsd_pkg;

    // coordinate width of the touch controller (8 to 15)
    localparam int COORD_BITS = 12;
    // width of the signed motion sums
    localparam int SUM_BITS   = 16;
    // width of the configuration values
    localparam int CFG_BITS   = 12;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE          = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_MOTION      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWIPE_THRESHOLD = 2'd2;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] MIN_MOTION_RESET      = 12'd3;
    localparam logic [CFG_BITS-1:0] SWIPE_THRESHOLD_RESET = 12'd50;

    // swipe direction codes
    typedef enum logic [2:0] {
        SWIPE_NONE  = 3'd0,
        SWIPE_LEFT  = 3'd1,
        SWIPE_RIGHT = 3'd2,
        SWIPE_UP    = 3'd3,
        SWIPE_DOWN  = 3'd4
    } dir_t;

    // one scan sample
    typedef struct packed {
        logic                  touch_down;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } tsd_in_t;

    // one result
    typedef struct packed {
        logic       held;
        logic       press_event;
        logic       release_event;
        logic       swipe_event;
        logic [2:0] swipe_dir;
    } tsd_out_t;

endpackage

// ===== hdl/tsd_in_stage.sv =====
`timescale 1ns / 1ps
// tsd_in_stage: input register of the detector, holds one scan request
// depends on tsd_pkg

module tsd_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tsd_pkg::tsd_in_t s_data,
    input  logic             take,
    output logic             item_valid,
    output tsd_pkg::tsd_in_t item
);
    import tsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    tsd_in_t data_reg;

    // free when empty or when the held request moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ===== hdl/tsd_core.sv =====
`timescale 1ns / 1ps
// tsd_core: configuration registers, touch state and the per-scan update
// depends on tsd_pkg

module tsd_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tsd_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  logic                              step,
    input  tsd_pkg::tsd_in_t                  item,
    output tsd_pkg::tsd_out_t                 result
);
    import tsd_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;

    // configuration
    logic                enable_reg;
    logic [CFG_BITS-1:0] min_motion_reg;
    logic [CFG_BITS-1:0] threshold_reg;

    // touch state
    logic                       held_reg,  held_next;
    logic [COORD_BITS-1:0]      prev_x_reg, prev_y_reg;
    logic signed [SUM_BITS-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_BITS-1:0] sum_y_reg, sum_y_next;
    dir_t                       dir_reg,   dir_next;
    logic                       done_reg,  done_next;

    // per-scan temporaries
    logic signed [DIFF_BITS-1:0] dx, dy;
    logic [DIFF_BITS-1:0]        mag_dx, mag_dy;
    logic [SUM_BITS-1:0]         mm_ext, th_ext;
    logic signed [SUM_BITS-1:0]  acc_x, acc_y;
    logic [SUM_BITS-1:0]         mag_sx, mag_sy;
    logic                        small_move;
    logic                        press_ev, release_ev, swipe_ev;

    // saturating add of a motion step to a sum
    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0]  s,
        input logic signed [DIFF_BITS-1:0] d
    );
        logic signed [SUM_BITS:0] wide;
        wide = (SUM_BITS+1)'(s) + (SUM_BITS+1)'(d);
        if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
            sat_add = wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            sat_add = wide[SUM_BITS-1:0];
        end
    endfunction

    // magnitude of a sum, full negative value fits unsigned
    function automatic logic [SUM_BITS-1:0] sum_mag(input logic signed [SUM_BITS-1:0] s);
        sum_mag = s[SUM_BITS-1] ? (~s + 1'b1) : s;
    endfunction

    // motion since the last point
    assign dx = signed'({1'b0, item.pos_x}) - signed'({1'b0, prev_x_reg});
    assign dy = signed'({1'b0, item.pos_y}) - signed'({1'b0, prev_y_reg});
    assign mag_dx = dx[DIFF_BITS-1] ? (~dx + 1'b1) : dx;
    assign mag_dy = dy[DIFF_BITS-1] ? (~dy + 1'b1) : dy;
    assign mm_ext = SUM_BITS'(min_motion_reg);
    assign th_ext = SUM_BITS'(threshold_reg);
    assign small_move = (SUM_BITS'(mag_dx) < mm_ext) && (SUM_BITS'(mag_dy) < mm_ext);

    // accumulated sums and their magnitudes
    assign acc_x  = sat_add(sum_x_reg, dx);
    assign acc_y  = sat_add(sum_y_reg, dy);
    assign mag_sx = sum_mag(acc_x);
    assign mag_sy = sum_mag(acc_y);

    // next state for this scan
    always_comb begin
        held_next  = held_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        dir_next   = dir_reg;
        done_next  = done_reg;
        press_ev   = 1'b0;
        release_ev = 1'b0;
        swipe_ev   = 1'b0;
        if (enable_reg) begin
            if (item.touch_down) begin
                held_next = 1'b1;
                if (!held_reg) begin
                    // start of a press
                    press_ev   = 1'b1;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    dir_next   = SWIPE_NONE;
                    done_next  = 1'b0;
                end else if (!done_reg) begin
                    if (small_move) begin
                        sum_x_next = '0;
                        sum_y_next = '0;
                    end else begin
                        sum_x_next = acc_x;
                        sum_y_next = acc_y;
                        if ((mag_sx > th_ext) || (mag_sy > th_ext)) begin
                            done_next = 1'b1;
                            swipe_ev  = 1'b1;
                            // ties go to the vertical axis
                            if (mag_sx > mag_sy) begin
                                dir_next = (acc_x > 0) ? SWIPE_RIGHT : SWIPE_LEFT;
                            end else begin
                                dir_next = (acc_y > 0) ? SWIPE_DOWN : SWIPE_UP;
                            end
                        end
                    end
                end
            end else begin
                release_ev = held_reg;
                held_next  = 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b1;
            min_motion_reg <= MIN_MOTION_RESET;
            threshold_reg  <= SWIPE_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENABLE:          enable_reg     <= cfg_wdata[0];
                REG_MIN_MOTION:      min_motion_reg <= cfg_wdata;
                REG_SWIPE_THRESHOLD: threshold_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // touch state update, one scan per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            dir_reg    <= SWIPE_NONE;
            done_reg   <= 1'b0;
        end else if (step) begin
            held_reg  <= held_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            dir_reg   <= dir_next;
            done_reg  <= done_next;
            if (enable_reg) begin
                prev_x_reg <= item.pos_x;
                prev_y_reg <= item.pos_y;
            end
        end
    end

    // result of this scan
    assign result.held          = held_next;
    assign result.press_event   = press_ev;
    assign result.release_event = release_ev;
    assign result.swipe_event   = swipe_ev;
    assign result.swipe_dir     = dir_next;

endmodule

// ===== hdl/tsd_out_stage.sv =====
`timescale 1ns / 1ps
// tsd_out_stage: result register of the detector, holds one result request
// depends on tsd_pkg

module tsd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tsd_pkg::tsd_out_t result,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output tsd_pkg::tsd_out_t m_data
);
    import tsd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    tsd_out_t data_reg;

    // room when empty or when the held result leaves this cycle
    assign room       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== hdl/touch_swipe_direction_detector.sv =====
`timescale 1ns / 1ps
// touch_swipe_direction_detector: top level, input register, update logic, result register
// depends on tsd_pkg, tsd_in_stage, tsd_core, tsd_out_stage
//
//  channel   ports                            width   direction
//  scan      s_valid / s_ready / s_data       25      in
//  result    m_valid / m_ready / m_data       7       out
//  config    cfg_wr_en / cfg_index / cfg_wdata 1+2+12 in
//
// One scan per cycle while m_ready keeps the result register draining; an accepted scan
// is held in the input register and its result in the result register, with the single
// update step between them reading and writing the touch state in the same cycle.
// Reset (aresetn low, synchronous) empties both registers and restores the state and
// configuration defaults. A stalled result holds the input register; s_ready falls
// only when both registers are full and m_ready is low.

module touch_swipe_direction_detector (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tsd_pkg::tsd_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tsd_pkg::tsd_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [tsd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tsd_pkg::CFG_BITS-1:0]     cfg_wdata
);
    import tsd_pkg::*;

    logic     item_valid;
    tsd_in_t  item;
    tsd_out_t result;
    logic     room;
    logic     step;

    // a held request moves on when the result register has room
    assign step = item_valid && room;

    tsd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    tsd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (item),
        .result    (result)
    );

    tsd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .result  (result),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
